>>> hdl/drfs_pkg.sv
`default_nettype none
package drfs_pkg;

   // panel geometry
   localparam int PANEL_WIDTH  = 160;
   localparam int PANEL_HEIGHT = 128;

   localparam int COORD_W = 8;                    // window coordinate width
   localparam int DIM_W   = 9;                    // clipped width/height, at most 160/128
   localparam int PIX_W   = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 1);
   localparam int STEP_W  = 4;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   // request kinds
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // header sequence positions
   localparam logic [STEP_W-1:0] STEP_COL_CMD = 4'd0;
   localparam logic [STEP_W-1:0] STEP_X0      = 4'd2;
   localparam logic [STEP_W-1:0] STEP_X1      = 4'd4;
   localparam logic [STEP_W-1:0] STEP_ROW_CMD = 4'd5;
   localparam logic [STEP_W-1:0] STEP_Y0      = 4'd7;
   localparam logic [STEP_W-1:0] STEP_Y1      = 4'd9;
   localparam logic [STEP_W-1:0] STEP_MEM_CMD = 4'd10;
   localparam logic [STEP_W-1:0] STEP_PIXELS  = 4'd11;

   // CSR indexes
   localparam logic [1:0] REG_COLUMN_CMD = 2'd0;
   localparam logic [1:0] REG_ROW_CMD    = 2'd1;
   localparam logic [1:0] REG_MEMWR_CMD  = 2'd2;

   localparam logic [7:0] COLUMN_CMD_RESET = 8'd42;
   localparam logic [7:0] ROW_CMD_RESET    = 8'd43;
   localparam logic [7:0] MEMWR_CMD_RESET  = 8'd44;

   localparam logic [7:0] PAD_BYTE = 8'h00;

   typedef struct packed {
      logic               empty;
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] y1;
      logic [DIM_W-1:0]   w;
      logic [DIM_W-1:0]   h;
   } clip_type;

endpackage
`default_nettype wire

>>> hdl/drfs_clip.sv
`default_nettype none
// Clips a signed rectangle against the panel.
module drfs_clip (
   input  wire logic [15:0]        rect_x,
   input  wire logic [15:0]        rect_y,
   input  wire logic [15:0]        rect_w,
   input  wire logic [15:0]        rect_h,
   output      drfs_pkg::clip_type clip
);

   localparam logic signed [17:0] PW = 18'(drfs_pkg::PANEL_WIDTH);
   localparam logic signed [17:0] PH = 18'(drfs_pkg::PANEL_HEIGHT);

   logic signed [17:0] x_s, y_s, w_s, h_s;
   logic signed [17:0] x_c, y_c, w_a, h_a, w_c, h_c;
   logic signed [17:0] x_end, y_end;
   logic signed [17:0] x_last, y_last;

   always_comb begin
      x_s = {{2{rect_x[15]}}, rect_x};
      y_s = {{2{rect_y[15]}}, rect_y};
      w_s = {{2{rect_w[15]}}, rect_w};
      h_s = {{2{rect_h[15]}}, rect_h};

      // pull left/top edge onto the panel
      x_c = x_s[17] ? 18'sd0 : x_s;
      w_a = x_s[17] ? (w_s + x_s) : w_s;
      y_c = y_s[17] ? 18'sd0 : y_s;
      h_a = y_s[17] ? (h_s + y_s) : h_s;

      // trim right/bottom edge
      x_end = x_c + w_a;
      y_end = y_c + h_a;
      w_c = (x_end > PW) ? (PW - x_c) : w_a;
      h_c = (y_end > PH) ? (PH - y_c) : h_a;

      x_last = x_c + w_c - 18'sd1;
      y_last = y_c + h_c - 18'sd1;

      clip.empty = (x_s >= PW) || (y_s >= PH) || (w_c <= 18'sd0) || (h_c <= 18'sd0);
      clip.x0    = x_c[drfs_pkg::COORD_W-1:0];
      clip.x1    = x_last[drfs_pkg::COORD_W-1:0];
      clip.y0    = y_c[drfs_pkg::COORD_W-1:0];
      clip.y1    = y_last[drfs_pkg::COORD_W-1:0];
      clip.w     = w_c[drfs_pkg::DIM_W-1:0];
      clip.h     = h_c[drfs_pkg::DIM_W-1:0];
   end

endmodule
`default_nettype wire

>>> hdl/display_rect_fill_stream.sv
`default_nettype none
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/stall     type, rect x/y/w/h, fill color
// rsp_      out        rsp_valid/stall     byte, is_data, frame_end, fill_done, rejected
// csr_      in/out     APB psel/penable    three 8-bit command bytes at 0x0/0x4/0x8
//
// Two register stages: the request is clipped into an input register, then
// sequencing logic updates the state and loads the result register. One transaction
// per cycle sustained unless a stalled result holds the input register.
// Reset is synchronous and returns the block to idle with default commands.
// A stalled result holds the result register and the input register with it,
// so req_stall is raised while a transaction waits in the input register behind it.
module display_rect_fill_stream (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_type,
   input  wire logic [15:0]                   req_rect_x,
   input  wire logic [15:0]                   req_rect_y,
   input  wire logic [15:0]                   req_rect_w,
   input  wire logic [15:0]                   req_rect_h,
   input  wire logic [15:0]                   req_fill_color,
   // response channel
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [7:0]                    rsp_out_byte,
   output      logic                          rsp_is_data,
   output      logic                          rsp_frame_end,
   output      logic                          rsp_fill_done,
   output      logic                          rsp_rejected,
   // configuration
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [drfs_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire logic [drfs_pkg::DATA_W-1:0]   csr_pwdata,
   output      logic [drfs_pkg::DATA_W-1:0]   csr_prdata,
   output      logic                          csr_pready
);

   // ---------------------------------------------------------------
   // CSRs
   // ---------------------------------------------------------------
   logic [7:0] col_cmd_ff, row_cmd_ff, mem_cmd_ff;
   logic       csr_wr;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cmd_ff <= drfs_pkg::COLUMN_CMD_RESET;
         row_cmd_ff <= drfs_pkg::ROW_CMD_RESET;
         mem_cmd_ff <= drfs_pkg::MEMWR_CMD_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            drfs_pkg::REG_COLUMN_CMD: col_cmd_ff <= csr_pwdata[7:0];
            drfs_pkg::REG_ROW_CMD:    row_cmd_ff <= csr_pwdata[7:0];
            drfs_pkg::REG_MEMWR_CMD:  mem_cmd_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         drfs_pkg::REG_COLUMN_CMD: csr_prdata = {24'd0, col_cmd_ff};
         drfs_pkg::REG_ROW_CMD:    csr_prdata = {24'd0, row_cmd_ff};
         drfs_pkg::REG_MEMWR_CMD:  csr_prdata = {24'd0, mem_cmd_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Stage 1: clip and register the request
   // ---------------------------------------------------------------
   drfs_pkg::clip_type clip_in;

   drfs_clip u_clip (
      .rect_x (req_rect_x),
      .rect_y (req_rect_y),
      .rect_w (req_rect_w),
      .rect_h (req_rect_h),
      .clip   (clip_in)
   );

   logic               s1_valid_ff;
   logic               s1_type_ff;
   drfs_pkg::clip_type s1_clip_ff;
   logic [15:0]        s1_color_ff;

   logic out_free;   // result register can take a new transaction
   logic advance;    // stage-1 transaction is processed this cycle

   assign out_free  = !rsp_valid || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_type_ff  <= req_type;
         s1_clip_ff  <= clip_in;
         s1_color_ff <= req_fill_color;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: fill sequencer state
   // ---------------------------------------------------------------
   logic                         busy_ff, busy_in;
   logic [drfs_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [drfs_pkg::PIX_W-1:0]   pix_left_ff, pix_left_in;
   logic                         low_ff, low_in;
   logic [7:0]                   x0_ff, x1_ff, y0_ff, y1_ff;
   logic [15:0]                  color_ff;
   logic                         load_win;

   logic [2*drfs_pkg::DIM_W-1:0] area;
   logic [drfs_pkg::PIX_W-1:0]   pix_dec;

   // result candidate
   logic       res_emit;
   logic [7:0] res_byte;
   logic       res_data, res_fend, res_done, res_rej;

   assign area    = s1_clip_ff.w * s1_clip_ff.h;
   assign pix_dec = (pix_left_ff != '0) ? (pix_left_ff - 1'b1) : pix_left_ff;

   always_comb begin
      busy_in     = busy_ff;
      step_in     = step_ff;
      pix_left_in = pix_left_ff;
      low_in      = low_ff;
      load_win    = 1'b0;
      res_emit    = 1'b0;
      res_byte    = drfs_pkg::PAD_BYTE;
      res_data    = 1'b0;
      res_fend    = 1'b0;
      res_done    = 1'b0;
      res_rej     = 1'b0;

      if (advance) begin
         if (s1_type_ff == drfs_pkg::REQ_START) begin
            if (busy_ff) begin
               // start while a fill runs: flag it, keep going
               res_emit = 1'b1;
               res_rej  = 1'b1;
            end else if (!s1_clip_ff.empty) begin
               load_win    = 1'b1;
               busy_in     = 1'b1;
               step_in     = '0;
               low_in      = 1'b0;
               pix_left_in = area[drfs_pkg::PIX_W-1:0];
            end
         end else if (busy_ff) begin
            res_emit = 1'b1;
            res_data = 1'b1;
            if (step_ff < drfs_pkg::STEP_PIXELS) begin
               step_in = step_ff + 1'b1;
               case (step_ff)
                  drfs_pkg::STEP_COL_CMD: begin
                     res_byte = col_cmd_ff;
                     res_data = 1'b0;
                  end
                  drfs_pkg::STEP_X0: res_byte = x0_ff;
                  drfs_pkg::STEP_X1: res_byte = x1_ff;
                  drfs_pkg::STEP_ROW_CMD: begin
                     res_byte = row_cmd_ff;
                     res_data = 1'b0;
                  end
                  drfs_pkg::STEP_Y0: res_byte = y0_ff;
                  drfs_pkg::STEP_Y1: res_byte = y1_ff;
                  drfs_pkg::STEP_MEM_CMD: begin
                     res_byte = mem_cmd_ff;
                     res_data = 1'b0;
                     res_fend = 1'b1;
                  end
                  default: res_byte = drfs_pkg::PAD_BYTE;
               endcase
            end else if (!low_ff) begin
               low_in   = 1'b1;
               res_byte = color_ff[15:8];
            end else begin
               low_in      = 1'b0;
               pix_left_in = pix_dec;
               res_byte    = color_ff[7:0];
               if (pix_dec == '0) begin
                  busy_in  = 1'b0;
                  step_in  = '0;
                  res_fend = 1'b1;
                  res_done = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         step_ff     <= '0;
         pix_left_ff <= '0;
         low_ff      <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         step_ff     <= step_in;
         pix_left_ff <= pix_left_in;
         low_ff      <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_win) begin
         x0_ff    <= s1_clip_ff.x0;
         x1_ff    <= s1_clip_ff.x1;
         y0_ff    <= s1_clip_ff.y0;
         y1_ff    <= s1_clip_ff.y1;
         color_ff <= s1_color_ff;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_data_ff, rsp_fend_ff, rsp_done_ff, rsp_rej_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (res_emit) begin
         rsp_byte_ff <= res_byte;
         rsp_data_ff <= res_data;
         rsp_fend_ff <= res_fend;
         rsp_done_ff <= res_done;
         rsp_rej_ff  <= res_rej;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_is_data   = rsp_data_ff;
   assign rsp_frame_end = rsp_fend_ff;
   assign rsp_fill_done = rsp_done_ff;
   assign rsp_rejected  = rsp_rej_ff;

endmodule
`default_nettype wire

>>> hdl/drfs_checker.sv
`default_nettype none
module drfs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_is_data,
   input wire logic       rsp_frame_end,
   input wire logic       rsp_fill_done,
   input wire logic       rsp_rejected
);

   // stalled result keeps its byte
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte))
      else $error("stalled result changed");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a reject carries no stream byte
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_out_byte == 8'h00 && !rsp_is_data
                                    && !rsp_frame_end && !rsp_fill_done)
      else $error("reject with payload");

   // the last byte of a fill is a data byte closing the frame
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fill_done |-> rsp_frame_end && rsp_is_data)
      else $error("fill_done without frame end");

endmodule

bind display_rect_fill_stream drfs_checker u_drfs_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_is_data   (rsp_is_data),
   .rsp_frame_end (rsp_frame_end),
   .rsp_fill_done (rsp_fill_done),
   .rsp_rejected  (rsp_rejected)
);
`default_nettype wire
